>>> design/adrs_pkg.sv
// Shared types, constants and defaults for the ATA DMA request splitter.
package adrs_pkg;

  localparam int DEF_MAX_CHUNK_SECTORS = 256;
  localparam int DEF_MAX_CHUNKS        = 64;
  localparam int DEF_QUEUE_DEPTH       = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_LBA48_MODE = 1'b0;

  localparam logic [7:0] SEL_BASE         = 8'h40;
  localparam logic [7:0] OPC_READ_DMA     = 8'hC8;
  localparam logic [7:0] OPC_READ_DMA_EXT = 8'h25;
  localparam logic [6:0] IFC_FROM_MEM     = 7'h4C;
  localparam logic [6:0] IFC_TO_MEM       = 7'h4E;
  localparam logic [7:0] XFER_BASE        = 8'h86;

  typedef struct packed {
    logic        device;
    logic [31:0] start_lba;
    logic [14:0] sector_count;
    logic [31:0] buffer_address;
    logic        direction;
  } req_t;

  typedef struct packed {
    logic        device;
    logic [31:0] start_lba;
    logic [14:0] sector_count;
    logic [31:0] buffer_address;
    logic [6:0]  if_ctrl_bits;
    logic [7:0]  xfer_ctrl;
  } job_t;

  typedef struct packed {
    logic [8:0]  chunk_count;
    logic [15:0] sector_value;
    logic [7:0]  cyl_low;
    logic [7:0]  cyl_high;
    logic [7:0]  select_value;
    logic [7:0]  opcode;
    logic [31:0] chunk_address;
    logic [6:0]  if_ctrl_bits;
    logic [7:0]  xfer_ctrl;
    logic        last;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

>>> design/adrs_front.sv
// Front end: accepts requests, drops empty ones and derives the direction controls.
module adrs_front (
  input  logic          push,
  output logic          full,
  input  adrs_pkg::req_t req,
  output logic          q_push,
  input  logic          q_full,
  output adrs_pkg::job_t q_job
);

  assign full   = q_full;
  assign q_push = push && !q_full && (req.sector_count != 15'd0);

  always_comb begin
    q_job.device         = req.device;
    q_job.start_lba      = req.start_lba;
    q_job.sector_count   = req.sector_count;
    q_job.buffer_address = req.buffer_address;
    q_job.if_ctrl_bits   = req.direction ? adrs_pkg::IFC_FROM_MEM : adrs_pkg::IFC_TO_MEM;
    q_job.xfer_ctrl      = adrs_pkg::XFER_BASE | {7'd0, req.direction};
  end

endmodule

>>> design/adrs_queue.sv
// Short job queue between the front end and the chunk sequencer.
module adrs_queue #(
  parameter int DEPTH = adrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  adrs_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd_en,
  output adrs_pkg::job_t rd_job,
  output logic           q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  adrs_pkg::job_t store_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign q_full  = (cnt_r == FULL_CNT);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = store_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store_r[wp_r] <= wr_job;
    end
  end

endmodule

>>> design/adrs_back.sv
// Chunk sequencer: cuts each job into chunks and builds the task file per chunk.
module adrs_back #(
  parameter int MAX_CHUNK_SECTORS = adrs_pkg::DEF_MAX_CHUNK_SECTORS,
  parameter int MAX_CHUNKS        = adrs_pkg::DEF_MAX_CHUNKS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           lba48_mode,
  input  adrs_pkg::job_t q_job,
  input  logic           q_empty,
  output logic           q_pop,
  output adrs_pkg::res_t res,
  output logic           empty,
  input  logic           pop
);

  localparam int NW = $clog2(MAX_CHUNKS + 1);
  localparam logic [8:0]    MAX_LEN  = 9'(MAX_CHUNK_SECTORS);
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_CHUNKS - 1);

  adrs_pkg::back_state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  adrs_pkg::res_t out_r, out_nxt;
  logic [31:0]    lba_r, lba_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic [14:0]    left_r, left_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic           dev_r, dev_nxt;
  logic [6:0]     ifc_r, ifc_nxt;
  logic [7:0]     xfer_r, xfer_nxt;
  logic           slot_free;
  logic [8:0]     len;
  logic [14:0]    left_after;
  logic           fin;
  logic           gen;

  assign slot_free  = !out_valid_r || pop;
  assign len        = (left_r > {6'd0, MAX_LEN}) ? MAX_LEN : left_r[8:0];
  assign left_after = left_r - {6'd0, len};
  assign fin        = (left_after == 15'd0) || (n_r == LAST_IDX);
  assign empty      = !out_valid_r;
  assign res        = out_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    gen       = 1'b0;
    lba_nxt   = lba_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    n_nxt     = n_r;
    dev_nxt   = dev_r;
    ifc_nxt   = ifc_r;
    xfer_nxt  = xfer_r;
    out_nxt   = out_r;
    unique case (state_r)
      adrs_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          lba_nxt   = q_job.start_lba;
          addr_nxt  = q_job.buffer_address;
          left_nxt  = q_job.sector_count;
          n_nxt     = '0;
          dev_nxt   = q_job.device;
          ifc_nxt   = q_job.if_ctrl_bits;
          xfer_nxt  = q_job.xfer_ctrl;
          state_nxt = adrs_pkg::BK_RUN;
        end
      end
      adrs_pkg::BK_RUN: begin
        if (slot_free) begin
          gen                   = 1'b1;
          out_nxt.chunk_count   = len;
          out_nxt.cyl_low       = lba_r[15:8];
          out_nxt.cyl_high      = lba_r[23:16];
          out_nxt.chunk_address = addr_r;
          out_nxt.if_ctrl_bits  = ifc_r;
          out_nxt.xfer_ctrl     = xfer_r;
          out_nxt.last          = fin;
          if (lba48_mode) begin
            out_nxt.sector_value = {lba_r[31:24], lba_r[7:0]};
            out_nxt.select_value = adrs_pkg::SEL_BASE | {3'd0, dev_r, 4'd0};
            out_nxt.opcode       = adrs_pkg::OPC_READ_DMA_EXT;
          end else begin
            out_nxt.sector_value = {8'd0, lba_r[7:0]};
            out_nxt.select_value = adrs_pkg::SEL_BASE | {3'd0, dev_r, lba_r[27:24]};
            out_nxt.opcode       = adrs_pkg::OPC_READ_DMA;
          end
          left_nxt = left_after;
          lba_nxt  = lba_r + {23'd0, len};
          addr_nxt = addr_r + {14'd0, len, 9'd0};
          n_nxt    = n_r + NW'(1);
          if (fin) begin
            state_nxt = adrs_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = adrs_pkg::BK_IDLE;
      end
    endcase
    out_valid_nxt = gen ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adrs_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    lba_r  <= lba_nxt;
    addr_r <= addr_nxt;
    left_r <= left_nxt;
    n_r    <= n_nxt;
    dev_r  <= dev_nxt;
    ifc_r  <= ifc_nxt;
    xfer_r <= xfer_nxt;
  end

`ifndef NO_ASSERTIONS
  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    gen && fin |=> state_r == adrs_pkg::BK_IDLE)
    else $error("job did not end after its last chunk");

  a_no_gen_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    gen |-> slot_free)
    else $error("chunk built while result slot held");

  a_chunk_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.chunk_count != 9'd0) && (out_r.chunk_count <= MAX_LEN))
    else $error("chunk size out of range");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == adrs_pkg::BK_IDLE && !q_empty)
    else $error("job taken while busy");
`endif

endmodule

>>> design/ata_dma_request_splitter_top.sv
// Top level: APB register, request front end, job queue and chunk sequencer.
// A request passes the job queue and the sequencer's job registers before its first chunk.
// Throughput: one chunk per cycle while the result slot is free; jobs are cut one at a time.
// A two-entry job queue lets the next requests be taken while one is still being cut.
// Requests with a zero sector count are taken and produce nothing.
// Synchronous active-low reset empties the queue and result register and clears lba48_mode.
module ata_dma_request_splitter_top #(
  parameter int MAX_CHUNK_SECTORS = adrs_pkg::DEF_MAX_CHUNK_SECTORS,
  parameter int MAX_CHUNKS        = adrs_pkg::DEF_MAX_CHUNKS,
  parameter int QUEUE_DEPTH       = adrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adrs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [adrs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [adrs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_device,
  input  logic [31:0]                     in_start_lba,
  input  logic [14:0]                     in_sector_count,
  input  logic [31:0]                     in_buffer_address,
  input  logic                            in_direction,
  output logic                            empty,
  input  logic                            pop,
  output logic [8:0]                      out_chunk_count,
  output logic [15:0]                     out_sector_value,
  output logic [7:0]                      out_cyl_low,
  output logic [7:0]                      out_cyl_high,
  output logic [7:0]                      out_select_value,
  output logic [7:0]                      out_opcode,
  output logic [31:0]                     out_chunk_address,
  output logic [6:0]                      out_if_ctrl_bits,
  output logic [7:0]                      out_xfer_ctrl,
  output logic                            out_last
);

  logic           lba48_mode_r, lba48_mode_nxt;
  logic           reg_hit;
  adrs_pkg::req_t req;
  adrs_pkg::job_t wr_job, rd_job;
  adrs_pkg::res_t res;
  logic           q_push, q_full, q_pop, q_empty;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == adrs_pkg::REG_LBA48_MODE);
  assign prdata  = {{(adrs_pkg::CFG_DATA_W-1){1'b0}}, reg_hit && lba48_mode_r};

  always_comb begin
    lba48_mode_nxt = lba48_mode_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      lba48_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba48_mode_r <= 1'b0;
    end else begin
      lba48_mode_r <= lba48_mode_nxt;
    end
  end

  always_comb begin
    req.device         = in_device;
    req.start_lba      = in_start_lba;
    req.sector_count   = in_sector_count;
    req.buffer_address = in_buffer_address;
    req.direction      = in_direction;
  end

  adrs_front u_front (
    .push   (push),
    .full   (full),
    .req    (req),
    .q_push (q_push),
    .q_full (q_full),
    .q_job  (wr_job)
  );

  adrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_job  (wr_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (rd_job),
    .q_empty (q_empty)
  );

  adrs_back #(
    .MAX_CHUNK_SECTORS (MAX_CHUNK_SECTORS),
    .MAX_CHUNKS        (MAX_CHUNKS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .lba48_mode (lba48_mode_r),
    .q_job      (rd_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .res        (res),
    .empty      (empty),
    .pop        (pop)
  );

  assign out_chunk_count   = res.chunk_count;
  assign out_sector_value  = res.sector_value;
  assign out_cyl_low       = res.cyl_low;
  assign out_cyl_high      = res.cyl_high;
  assign out_select_value  = res.select_value;
  assign out_opcode        = res.opcode;
  assign out_chunk_address = res.chunk_address;
  assign out_if_ctrl_bits  = res.if_ctrl_bits;
  assign out_xfer_ctrl     = res.xfer_ctrl;
  assign out_last          = res.last;

endmodule

>>> sim/ata_dma_request_splitter_top_tb.sv
// Testbench for the ATA DMA request splitter: random and corner requests, chunk-by-chunk checks.
`timescale 1ns / 100ps

module ata_dma_request_splitter_top_tb;

  localparam int          MAX_SECTORS  = adrs_pkg::DEF_MAX_CHUNK_SECTORS;
  localparam int          MAX_PIECES   = adrs_pkg::DEF_MAX_CHUNKS;
  localparam int          LIMIT        = 1000000;
  localparam int          DRAIN_CYCLES = 16;
  localparam logic [adrs_pkg::CFG_ADDR_W-1:0] ADDR_LBA48_MODE =
    adrs_pkg::CFG_ADDR_W'(4 * adrs_pkg::REG_LBA48_MODE);
  localparam logic [adrs_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED = adrs_pkg::CFG_ADDR_W'(4);

  class chunk_book;
    logic lba48;
    adrs_pkg::res_t pending[$];
    int   mismatches;

    function new();
      lba48 = 1'b0;
      mismatches = 0;
    endfunction

    function void split_request(adrs_pkg::req_t r);
      logic [31:0]    lba;
      logic [31:0]    addr;
      int unsigned    left;
      int unsigned    len;
      int             n;
      adrs_pkg::res_t c;
      lba = r.start_lba;
      addr = r.buffer_address;
      left = 32'(r.sector_count);
      n = 0;
      while (left != 0 && n < MAX_PIECES) begin
        len = (left > MAX_SECTORS) ? MAX_SECTORS : left;
        left -= len;
        c.chunk_count = len[8:0];
        if (lba48) begin
          c.sector_value = {lba[31:24], lba[7:0]};
          c.select_value = adrs_pkg::SEL_BASE | {3'b000, r.device, 4'h0};
          c.opcode = adrs_pkg::OPC_READ_DMA_EXT;
        end else begin
          c.sector_value = {8'h00, lba[7:0]};
          c.select_value = adrs_pkg::SEL_BASE | {3'b000, r.device, lba[27:24]};
          c.opcode = adrs_pkg::OPC_READ_DMA;
        end
        c.cyl_low = lba[15:8];
        c.cyl_high = lba[23:16];
        c.chunk_address = addr;
        c.if_ctrl_bits = r.direction ? adrs_pkg::IFC_FROM_MEM : adrs_pkg::IFC_TO_MEM;
        c.xfer_ctrl = adrs_pkg::XFER_BASE | {7'h00, r.direction};
        c.last = (left == 0) || (n + 1 == MAX_PIECES);
        pending.push_back(c);
        addr = addr + len * 512;
        lba = lba + len;
        n++;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_chunk(adrs_pkg::res_t got);
      adrs_pkg::res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t unexpected chunk: expected none, actual 0x%0h", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("chunk_count", 32'(want.chunk_count), 32'(got.chunk_count));
      compare_field("sector_value", 32'(want.sector_value), 32'(got.sector_value));
      compare_field("cyl_low", 32'(want.cyl_low), 32'(got.cyl_low));
      compare_field("cyl_high", 32'(want.cyl_high), 32'(got.cyl_high));
      compare_field("select_value", 32'(want.select_value), 32'(got.select_value));
      compare_field("opcode", 32'(want.opcode), 32'(got.opcode));
      compare_field("chunk_address", want.chunk_address, got.chunk_address);
      compare_field("if_ctrl_bits", 32'(want.if_ctrl_bits), 32'(got.if_ctrl_bits));
      compare_field("xfer_ctrl", 32'(want.xfer_ctrl), 32'(got.xfer_ctrl));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [adrs_pkg::CFG_ADDR_W-1:0]     paddr = '0;
  logic [adrs_pkg::CFG_DATA_W-1:0]     pwdata = '0;
  logic [adrs_pkg::CFG_DATA_W-1:0]     prdata;
  logic                                pready;
  logic                                push = 1'b0;
  logic                                full;
  logic                                in_device = 1'b0;
  logic [31:0]                         in_start_lba = '0;
  logic [14:0]                         in_sector_count = '0;
  logic [31:0]                         in_buffer_address = '0;
  logic                                in_direction = 1'b0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic [8:0]                          out_chunk_count;
  logic [15:0]                         out_sector_value;
  logic [7:0]                          out_cyl_low;
  logic [7:0]                          out_cyl_high;
  logic [7:0]                          out_select_value;
  logic [7:0]                          out_opcode;
  logic [31:0]                         out_chunk_address;
  logic [6:0]                          out_if_ctrl_bits;
  logic [7:0]                          out_xfer_ctrl;
  logic                                out_last;

  chunk_book book = new();
  bit        idle_on = 1'b1;
  int        cycles = 0;

  ata_dma_request_splitter_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .full              (full),
    .in_device         (in_device),
    .in_start_lba      (in_start_lba),
    .in_sector_count   (in_sector_count),
    .in_buffer_address (in_buffer_address),
    .in_direction      (in_direction),
    .empty             (empty),
    .pop               (pop),
    .out_chunk_count   (out_chunk_count),
    .out_sector_value  (out_sector_value),
    .out_cyl_low       (out_cyl_low),
    .out_cyl_high      (out_cyl_high),
    .out_select_value  (out_select_value),
    .out_opcode        (out_opcode),
    .out_chunk_address (out_chunk_address),
    .out_if_ctrl_bits  (out_if_ctrl_bits),
    .out_xfer_ctrl     (out_xfer_ctrl),
    .out_last          (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL ata_dma_request_splitter_top");
      $finish;
    end
  end

  function automatic adrs_pkg::req_t make_req(logic dev, logic [31:0] lba, logic [14:0] cnt,
                                              logic [31:0] addr, logic dir);
    adrs_pkg::req_t r;
    r.device = dev;
    r.start_lba = lba;
    r.sector_count = cnt;
    r.buffer_address = addr;
    r.direction = dir;
    return r;
  endfunction

  function automatic adrs_pkg::req_t random_request();
    adrs_pkg::req_t r;
    int unsigned    pick;
    r.device = 1'($urandom_range(0, 1));
    r.direction = 1'($urandom_range(0, 1));
    r.start_lba = $urandom;
    r.buffer_address = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.sector_count = 15'($urandom_range(1, 256));
    else if (pick < 65) r.sector_count = 15'($urandom_range(257, 2048));
    else if (pick < 75) r.sector_count = 15'd0;
    else if (pick < 85) r.sector_count = 15'(256 * $urandom_range(1, 8));
    else if (pick < 93) r.sector_count = 15'($urandom_range(2049, 16384));
    else r.sector_count = 15'($urandom_range(0, 32767));
    pick = $urandom_range(0, 99);
    if (pick < 15) r.start_lba = 32'hFFFF_FFFF - $urandom_range(0, 600);
    else if (pick < 25) r.start_lba = 32'h1000_0000 - $urandom_range(0, 600);
    if ($urandom_range(0, 99) < 15) r.buffer_address = 32'hFFFF_FFFF - $urandom_range(0, 32'h40000);
    return r;
  endfunction

  task automatic send_request(adrs_pkg::req_t r);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_device <= r.device;
    in_start_lba <= r.start_lba;
    in_sector_count <= r.sector_count;
    in_buffer_address <= r.buffer_address;
    in_direction <= r.direction;
    do @(posedge clk); while (full);
    book.split_request(r);
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [adrs_pkg::CFG_ADDR_W-1:0] addr,
                            logic [adrs_pkg::CFG_DATA_W-1:0] data);
    logic [adrs_pkg::CFG_DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr && addr == ADDR_LBA48_MODE) book.lba48 = data[0];
    if (!wr) book.compare_field("lba48_mode readback", {31'd0, book.lba48}, rd);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(logic [adrs_pkg::CFG_ADDR_W-1:0] addr,
                          logic [adrs_pkg::CFG_DATA_W-1:0] data);
    cfg_access(1'b1, addr, data);
    cfg_access(1'b0, ADDR_LBA48_MODE, '0);
  endtask

  task automatic run_corners();
    adrs_pkg::req_t corners[$];
    corners.push_back(make_req(1'b0, 32'h0, 15'd0, 32'h0, 1'b0));
    corners.push_back(make_req(1'b0, 32'h0, 15'd1, 32'h0, 1'b0));
    corners.push_back(make_req(1'b1, 32'hFFFF_FFFF, 15'd256, 32'hFFFF_FFFF, 1'b1));
    corners.push_back(make_req(1'b0, 32'h0FFF_FFFF, 15'd257, 32'hFFFF_FE00, 1'b1));
    corners.push_back(make_req(1'b1, 32'hFFFF_FF00, 15'd16384, 32'h1234_5678, 1'b0));
    corners.push_back(make_req(1'b0, 32'h8765_4321, 15'd16385, 32'hFFF0_0000, 1'b1));
    corners.push_back(make_req(1'b1, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF, 1'b1));
    corners.push_back(make_req(1'b1, 32'hF000_0000, 15'd255, 32'h8000_0000, 1'b0));
    corners.push_back(make_req(1'b0, 32'h00FF_FF80, 15'd512, 32'h7FFF_FF00, 1'b1));
    corners.push_back(make_req(1'b1, 32'hFFFF_FFFF, 15'd0, 32'hFFFF_FFFF, 1'b1));
    foreach (corners[i]) send_request(corners[i]);
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (idle_on && stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty)
        book.check_chunk({out_chunk_count, out_sector_value, out_cyl_low, out_cyl_high,
                          out_select_value, out_opcode, out_chunk_address,
                          out_if_ctrl_bits, out_xfer_ctrl, out_last});
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_mode(ADDR_LBA48_MODE, 32'h0);
    run_corners();
    settle();
    set_mode(ADDR_LBA48_MODE, 32'h1);
    run_corners();
    settle();
    set_mode(ADDR_UNMAPPED, 32'h0);
    set_mode(ADDR_LBA48_MODE, 32'hFFFF_FFFE);
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) idle_on = 1'b0;
      repeat (phase == 4 ? 60 : 65) send_request(random_request());
      settle();
      if ($urandom_range(0, 4) == 0) set_mode(ADDR_UNMAPPED, $urandom);
      set_mode(ADDR_LBA48_MODE, (phase % 2 == 0) ? 32'hFFFF_FFFF : $urandom);
    end
    settle();
    if (book.mismatches == 0 && book.pending.size() == 0)
      $display("PASS ata_dma_request_splitter_top");
    else
      $display("FAIL ata_dma_request_splitter_top");
    $finish;
  end

endmodule

>>> ata_dma_request_splitter_top.f
design/adrs_pkg.sv
design/adrs_front.sv
design/adrs_queue.sv
design/adrs_back.sv
design/ata_dma_request_splitter_top.sv
sim/ata_dma_request_splitter_top_tb.sv
